### hdl/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, codes and alphabet helpers for the unpadded URL-safe base64
// stream codec.
// ----------------------------------------------------------------------------
package b64u_pkg;

   // configuration register indexes
   localparam logic [0:0] CSR_DIRECTION = 1'd0;
   localparam logic [0:0] CSR_MAX_OUT   = 1'd1;

   // direction codes
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // position inside a three-byte / four-character group
   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;
   localparam logic [1:0] PHASE_3 = 2'd3;

   localparam int unsigned OUT_COUNT_BITS = 16;

   // alphabet edges
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
   localparam logic [7:0] CHAR_DASH    = 8'h2d;
   localparam logic [7:0] CHAR_UNDER   = 8'h5f;

   // one result item
   typedef struct packed {
      logic [7:0]                data;
      logic                      has_data;
      logic                      last;
      logic [OUT_COUNT_BITS-1:0] count;
   } result_type;

   // results produced by one input item, at most two
   typedef struct packed {
      logic [1:0] num;
      result_type r0;
      result_type r1;
   } push_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] val;
   } sixbit_type;

   // six-bit value to alphabet character
   function automatic logic [7:0] sixbit_to_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = CHAR_UPPER_A + {2'b00, v};
      end else if (v < 6'd52) begin
         c = CHAR_LOWER_A + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         c = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         c = CHAR_DASH;
      end else begin
         c = CHAR_UNDER;
      end
      return c;
   endfunction

   // alphabet character to six-bit value, ok low outside the alphabet
   function automatic sixbit_type char_to_sixbit(input logic [7:0] c);
      sixbit_type s;
      logic [7:0] d;
      s = '0;
      d = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d = c - CHAR_UPPER_A;
         s.ok = 1'b1;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d = c - CHAR_LOWER_A + 8'd26;
         s.ok = 1'b1;
      end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = c - CHAR_DIGIT_0 + 8'd52;
         s.ok = 1'b1;
      end else if (c == CHAR_DASH) begin
         d = 8'd62;
         s.ok = 1'b1;
      end else if (c == CHAR_UNDER) begin
         d = 8'd63;
         s.ok = 1'b1;
      end
      s.val = d[5:0];
      return s;
   endfunction

endpackage

### hdl/base64url_stream_codec_core.sv
// ----------------------------------------------------------------------------
// base64url_stream_codec_core
// Unpadded URL-safe base64 stream codec, encode or decode by register.
// ----------------------------------------------------------------------------
// An accepted item passes through the input register and then the result
// queue before its first result is on rsp. Throughput: one item per cycle
// while items give one result each and rsp is not stalled; an item that gives
// two results holds the result channel longer. Reset is synchronous and
// clears message state, the queue, and sets direction to encode and
// max_out_bytes to 65535.
module base64url_stream_codec_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_data,
   output logic        rsp_out_has_data,
   output logic        rsp_out_last,
   output logic [15:0] rsp_out_count,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wr_data
);
   import b64u_pkg::*;

   logic        direction_ff;
   logic [15:0] max_out_ff;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        room;
   logic        fire;
   logic        accept;
   push_type    push;
   result_type  rsp_item;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ENCODE;
         max_out_ff   <= 16'hffff;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DIRECTION: direction_ff <= csr_wr_data[0];
            CSR_MAX_OUT:   max_out_ff   <= csr_wr_data;
            default:       ;
         endcase
      end
   end

   // input register, drained when the queue has two free slots
   assign fire        = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   b64u_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .in_byte       (in_byte_ff),
      .in_last       (in_last_ff),
      .direction     (direction_ff),
      .max_out_bytes (max_out_ff),
      .push          (push)
   );

   b64u_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_en   (fire),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_out_data     = rsp_item.data;
   assign rsp_out_has_data = rsp_item.has_data;
   assign rsp_out_last     = rsp_item.last;
   assign rsp_out_count    = rsp_item.count;

endmodule

### hdl/b64u_step.sv
// ----------------------------------------------------------------------------
// b64u_step
// Message state and the per-item encode / decode logic. One item is handled
// in the cycle it fires and yields up to two result items.
// ----------------------------------------------------------------------------
module b64u_step #(
   parameter int COUNT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   input  logic                direction,
   input  logic [15:0]         max_out_bytes,
   output b64u_pkg::push_type  push
);
   import b64u_pkg::*;

   localparam int CMP_W = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

   logic [1:0]            phase_ff, phase_in;
   logic [5:0]            held_ff, held_in;
   logic                  stopped_ff, stopped_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [COUNT_BITS-1:0] count_p1, count_p2;
   logic [CMP_W-1:0]      cur_w, p1_w, p2_w, max_w;
   logic [1:0]            enc_phase;
   sixbit_type            dec;

   // saturating counts for the first and second data result
   always_comb begin
      count_p1 = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      count_p2 = (count_p1 == '1) ? count_p1 : count_p1 + 1'b1;
      cur_w    = CMP_W'(count_ff);
      p1_w     = CMP_W'(count_p1);
      p2_w     = CMP_W'(count_p2);
      max_w    = CMP_W'(max_out_bytes);
   end

   assign enc_phase = (phase_ff == PHASE_3) ? PHASE_0 : phase_ff;
   assign dec       = char_to_sixbit(in_byte);

   // next state and results
   always_comb begin
      phase_in   = phase_ff;
      held_in    = held_ff;
      stopped_in = stopped_ff;
      count_in   = count_ff;
      push       = '0;
      push.r0.count = p1_w[OUT_COUNT_BITS-1:0];
      push.r1.count = p2_w[OUT_COUNT_BITS-1:0];

      if (direction == DIR_ENCODE) begin
         push.num         = 2'd1;
         push.r0.has_data = 1'b1;
         push.r1.has_data = 1'b1;
         case (enc_phase)
            PHASE_1: begin
               push.r0.data = sixbit_to_char(held_ff | {2'b00, in_byte[7:4]});
               held_in      = {in_byte[3:0], 2'b00};
               phase_in     = PHASE_2;
            end
            PHASE_2: begin
               push.r0.data = sixbit_to_char(held_ff | {4'b0000, in_byte[7:6]});
               push.r1.data = sixbit_to_char(in_byte[5:0]);
               push.num     = 2'd2;
               held_in      = '0;
               phase_in     = PHASE_0;
            end
            default: begin
               push.r0.data = sixbit_to_char(in_byte[7:2]);
               held_in      = {in_byte[1:0], 4'b0000};
               phase_in     = PHASE_1;
            end
         endcase
         // flush the partial group, or mark the final character
         if (in_last) begin
            if (phase_in != PHASE_0) begin
               push.r1.data = sixbit_to_char(held_in);
               push.r1.last = 1'b1;
               push.num     = 2'd2;
            end else begin
               push.r1.last = 1'b1;
            end
         end
         count_in = (push.num == 2'd2) ? count_p2 : count_p1;
      end else begin
         // decode one character
         if (!stopped_ff) begin
            if (!dec.ok) begin
               stopped_in = 1'b1;
            end else if (phase_ff == PHASE_0) begin
               held_in  = dec.val;
               phase_in = PHASE_1;
            end else if (cur_w >= max_w) begin
               stopped_in = 1'b1;
            end else begin
               case (phase_ff)
                  PHASE_1: begin
                     push.r0.data = {held_ff, dec.val[5:4]};
                     held_in      = {2'b00, dec.val[3:0]};
                     phase_in     = PHASE_2;
                  end
                  PHASE_2: begin
                     push.r0.data = {held_ff[3:0], dec.val[5:2]};
                     held_in      = {4'b0000, dec.val[1:0]};
                     phase_in     = PHASE_3;
                  end
                  default: begin
                     push.r0.data = {held_ff[1:0], dec.val};
                     held_in      = '0;
                     phase_in     = PHASE_0;
                  end
               endcase
               push.num         = 2'd1;
               push.r0.has_data = 1'b1;
               push.r0.last     = in_last;
               count_in         = count_p1;
               if (p1_w >= max_w) begin
                  stopped_in = 1'b1;
               end
            end
         end
         // end marker when the final character gave no byte
         if (in_last && push.num == 2'd0) begin
            push.num      = 2'd1;
            push.r0.data  = '0;
            push.r0.last  = 1'b1;
            push.r0.count = cur_w[OUT_COUNT_BITS-1:0];
         end
      end

      // message end clears the group state
      if (in_last) begin
         phase_in   = PHASE_0;
         held_in    = '0;
         stopped_in = 1'b0;
         count_in   = '0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_0;
         held_ff    <= '0;
         stopped_ff <= 1'b0;
         count_ff   <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         held_ff    <= held_in;
         stopped_ff <= stopped_in;
         count_ff   <= count_in;
      end
   end

`ifndef SYNTHESIS
   // encoding always yields at least one character
   a_enc_nonempty: assert property (@(posedge clock) disable iff (reset)
      fire && direction == DIR_ENCODE |-> push.num != 2'd0)
      else $error("encode item produced no result");

   // a message end leaves clean group state behind
   a_msg_clear: assert property (@(posedge clock) disable iff (reset)
      fire && in_last |=> phase_ff == PHASE_0 && count_ff == '0 && !stopped_ff)
      else $error("state not cleared at message end");
`endif

endmodule

### hdl/b64u_rsp_queue.sv
// ----------------------------------------------------------------------------
// b64u_rsp_queue
// Four-entry result queue. Takes up to two result items per cycle and
// presents one item per cycle on the result channel while rsp_stall is low.
// ----------------------------------------------------------------------------
module b64u_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  b64u_pkg::push_type    push,
   input  logic                  push_en,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output b64u_pkg::result_type  rsp_item
);
   import b64u_pkg::*;

   result_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [1:0] num;
   logic       pop;

   assign room      = (cnt_ff <= 3'd2);
   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_item  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign num       = push_en ? push.num : 2'd0;

   // pointer and fill arithmetic
   always_comb begin
      wr_ptr_in = wr_ptr_ff + num;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      cnt_in    = cnt_ff + {1'b0, num} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.r0;
      end
      if (num == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.r1;
      end
   end

`ifndef SYNTHESIS
   // fill level never passes the depth
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result queue overflow");

   // items are pushed only when two slots are free
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      num != 2'd0 |-> cnt_ff <= 3'd2)
      else $error("push without room");
`endif

endmodule
